// ===== src/tgc_pkg.sv =====
// tgc_pkg: shared types, widths, codes and constants of the touch gesture classifier
// used by every file of the block; no dependencies
`timescale 1ns / 1ps

package tgc_pkg;

  // field and register widths
  localparam int unsigned RegW    = 12;
  localparam int unsigned PosW    = 12;
  localparam int unsigned OpW     = 2;
  localparam int unsigned SlotW   = 4;
  localparam int unsigned MaskW   = 12;
  localparam int unsigned CountW  = 6;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned SqW     = 2 * PosW + 1;

  // divide by three through a reciprocal, exact for 12-bit operands
  localparam int unsigned Recip3      = 2731;
  localparam int unsigned Recip3Shift = 13;

  // fixed screen margins and counter limits
  localparam int unsigned TapEdge    = 100;
  localparam int unsigned CornerEdge = 150;
  localparam int unsigned TouchMax   = 63;
  localparam int unsigned FingerMax  = 31;

  // register reset values
  localparam int unsigned JitterRst = 20;
  localparam int unsigned LongRst   = 600;
  localparam int unsigned WidthRst  = 1404;
  localparam int unsigned HeightRst = 1872;
  localparam int unsigned WideRst   = 400;

  // derived threshold reset values
  localparam int unsigned WThirdRst  = WidthRst / 3;
  localparam int unsigned HThirdRst  = HeightRst / 3;
  localparam int unsigned WideSqRst  = (WideRst + 1) * (WideRst + 1);

  typedef enum logic [OpW-1:0] {
    OP_DOWN  = 2'd0,
    OP_UP    = 2'd1,
    OP_OTHER = 2'd2
  } op_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_JITTER = 3'd0,
    CFG_LONG_H = 3'd1,
    CFG_LONG_V = 3'd2,
    CFG_WIDTH  = 3'd3,
    CFG_HEIGHT = 3'd4,
    CFG_WIDE   = 3'd5
  } cfg_idx_e;

  // thresholds as seen by the datapath
  typedef struct packed {
    logic [RegW-1:0] jitter;
    logic [RegW-1:0] long_h;
    logic [RegW-1:0] long_v;
    logic [RegW-1:0] height;
    logic [RegW-1:0] w_third;
    logic [RegW-1:0] w_two_thirds;
    logic [RegW-1:0] h_third;
    logic [RegW-1:0] h_two_thirds;
    logic [SqW-1:0]  wide_sq;
  } cfg_t;

  // finished gesture between the state stage and the distance stage
  typedef struct packed {
    logic [MaskW-1:0]  single_mask;
    logic              two_tap;
    logic [CountW-1:0] touches;
    logic [PosW-1:0]   sep_x;
    logic [PosW-1:0]   sep_y;
  } mid_t;

  // floor(v / 3) for a 12-bit value
  function automatic logic [RegW-1:0] third(input logic [RegW-1:0] v);
    logic [2*RegW-1:0] prod;
    prod = (2*RegW)'(v) * (2*RegW)'(Recip3);
    return RegW'(prod >> Recip3Shift);
  endfunction

endpackage

// ===== src/tgc_if.sv =====
// tgc_if: valid/ready channels for touch events and gesture results
// depends on tgc_pkg for field widths
`timescale 1ns / 1ps

interface tgc_evt_if;
  logic                     valid;
  logic                     ready;
  logic [tgc_pkg::OpW-1:0]   op;
  logic [tgc_pkg::SlotW-1:0] slot;
  logic [tgc_pkg::PosW-1:0]  touch_x;
  logic [tgc_pkg::PosW-1:0]  touch_y;

  modport source (output valid, op, slot, touch_x, touch_y, input ready);
  modport sink (input valid, op, slot, touch_x, touch_y, output ready);
endinterface

interface tgc_res_if;
  logic                       valid;
  logic                       ready;
  logic [tgc_pkg::MaskW-1:0]  single_mask;
  logic                       two_tap;
  logic                       two_tap_wide;
  logic [tgc_pkg::CountW-1:0] touches_seen;

  modport source (output valid, single_mask, two_tap, two_tap_wide, touches_seen,
                  input ready);
  modport sink (input valid, single_mask, two_tap, two_tap_wide, touches_seen,
                output ready);
endinterface

// ===== src/tgc_cfg_regs.sv =====
// tgc_cfg_regs: threshold registers and the thresholds derived from them
// depends on tgc_pkg
`timescale 1ns / 1ps

module tgc_cfg_regs (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [tgc_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [tgc_pkg::RegW-1:0]     cfg_wdata_i,
  output tgc_pkg::cfg_t                cfg_o
);

  localparam int unsigned RegW = tgc_pkg::RegW;
  localparam int unsigned SqW  = tgc_pkg::SqW;

  logic [RegW-1:0] jitter_q, long_h_q, long_v_q, width_q, height_q, wide_q;
  logic [RegW-1:0] w_third_q, w_two_q, h_third_q, h_two_q;
  logic [SqW-1:0]  wide_sq_q;
  logic [RegW-1:0] w_third_d, h_third_d;
  logic [RegW:0]   wide_p1;
  logic [2*RegW+1:0] wide_prod;

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      jitter_q <= RegW'(tgc_pkg::JitterRst);
      long_h_q <= RegW'(tgc_pkg::LongRst);
      long_v_q <= RegW'(tgc_pkg::LongRst);
      width_q  <= RegW'(tgc_pkg::WidthRst);
      height_q <= RegW'(tgc_pkg::HeightRst);
      wide_q   <= RegW'(tgc_pkg::WideRst);
    end else if (cfg_we_i) begin
      unique case (tgc_pkg::cfg_idx_e'(cfg_idx_i))
        tgc_pkg::CFG_JITTER: jitter_q <= cfg_wdata_i;
        tgc_pkg::CFG_LONG_H: long_h_q <= cfg_wdata_i;
        tgc_pkg::CFG_LONG_V: long_v_q <= cfg_wdata_i;
        tgc_pkg::CFG_WIDTH:  width_q  <= cfg_wdata_i;
        tgc_pkg::CFG_HEIGHT: height_q <= cfg_wdata_i;
        tgc_pkg::CFG_WIDE:   wide_q   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // screen thirds and squared wide distance
  assign w_third_d = tgc_pkg::third(width_q);
  assign h_third_d = tgc_pkg::third(height_q);
  assign wide_p1   = (RegW+1)'(wide_q) + (RegW+1)'(1);
  assign wide_prod = (2*RegW+2)'(wide_p1) * (2*RegW+2)'(wide_p1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_third_q <= RegW'(tgc_pkg::WThirdRst);
      w_two_q   <= RegW'(2 * tgc_pkg::WThirdRst);
      h_third_q <= RegW'(tgc_pkg::HThirdRst);
      h_two_q   <= RegW'(2 * tgc_pkg::HThirdRst);
      wide_sq_q <= SqW'(tgc_pkg::WideSqRst);
    end else begin
      w_third_q <= w_third_d;
      w_two_q   <= {w_third_d[RegW-2:0], 1'b0};
      h_third_q <= h_third_d;
      h_two_q   <= {h_third_d[RegW-2:0], 1'b0};
      wide_sq_q <= wide_prod[SqW-1:0];
    end
  end

  always_comb begin
    cfg_o.jitter       = jitter_q;
    cfg_o.long_h       = long_h_q;
    cfg_o.long_v       = long_v_q;
    cfg_o.height       = height_q;
    cfg_o.w_third      = w_third_q;
    cfg_o.w_two_thirds = w_two_q;
    cfg_o.h_third      = h_third_q;
    cfg_o.h_two_thirds = h_two_q;
    cfg_o.wide_sq      = wide_sq_q;
  end

endmodule

// ===== src/tgc_tap_swipe.sv =====
// tgc_tap_swipe: tap and swipe tests of a one-finger gesture
// depends on tgc_pkg
`timescale 1ns / 1ps

module tgc_tap_swipe (
  input  tgc_pkg::cfg_t               cfg_i,
  input  logic [tgc_pkg::PosW-1:0]    pos_x_i,
  input  logic [tgc_pkg::PosW-1:0]    pos_y_i,
  input  logic [tgc_pkg::PosW-1:0]    start_x_i,
  input  logic [tgc_pkg::PosW-1:0]    start_y_i,
  output logic [tgc_pkg::MaskW-1:0]   mask_o
);

  localparam int unsigned PosW = tgc_pkg::PosW;

  logic [PosW:0]   dx, dy;
  logic [PosW-1:0] ax, ay;
  logic            neg_x, neg_y, nz_x, nz_y;
  logic            tap, moved, horiz, vert;
  logic            y_low_ok, corner_ok;

  // movement and its magnitude
  assign dx    = (PosW+1)'(pos_x_i) - (PosW+1)'(start_x_i);
  assign dy    = (PosW+1)'(pos_y_i) - (PosW+1)'(start_y_i);
  assign neg_x = dx[PosW];
  assign neg_y = dy[PosW];
  assign ax    = PosW'(neg_x ? ((PosW+1)'(0) - dx) : dx);
  assign ay    = PosW'(neg_y ? ((PosW+1)'(0) - dy) : dy);
  assign nz_x  = (ax != '0);
  assign nz_y  = (ay != '0);

  // movement class
  assign tap   = (ax < cfg_i.jitter) && (ay < cfg_i.jitter);
  assign moved = (ax > cfg_i.jitter) || (ay > cfg_i.jitter);
  assign horiz = moved && (ax > ay);
  assign vert  = moved && (ay > ax);

  // lower left corner is excluded from the left tap
  assign y_low_ok  = ((PosW+1)'(pos_y_i) + (PosW+1)'(tgc_pkg::CornerEdge))
                     < (PosW+1)'(cfg_i.height);
  assign corner_ok = y_low_ok || (pos_x_i > PosW'(tgc_pkg::CornerEdge));

  always_comb begin
    mask_o = '0;
    // taps
    mask_o[0] = tap && (pos_y_i > PosW'(tgc_pkg::TapEdge)) && (pos_x_i < cfg_i.w_third)
                && corner_ok;
    mask_o[1] = tap && (pos_y_i > PosW'(tgc_pkg::TapEdge)) && (pos_x_i > cfg_i.w_two_thirds);
    mask_o[2] = tap && (pos_x_i > PosW'(tgc_pkg::TapEdge)) && (pos_y_i < cfg_i.h_third);
    mask_o[3] = tap && (pos_x_i > PosW'(tgc_pkg::TapEdge)) && (pos_y_i > cfg_i.h_two_thirds);
    // short swipes
    mask_o[4] = horiz && neg_x && (ax < cfg_i.long_h);
    mask_o[5] = horiz && !neg_x && nz_x && (ax < cfg_i.long_h);
    mask_o[6] = vert && neg_y && (ay < cfg_i.long_v);
    mask_o[7] = vert && !neg_y && nz_y && (ay < cfg_i.long_v);
    // long swipes
    mask_o[8]  = horiz && neg_x && (ax > cfg_i.long_h);
    mask_o[9]  = horiz && !neg_x && (ax > cfg_i.long_h);
    mask_o[10] = vert && neg_y && (ay > cfg_i.long_v);
    mask_o[11] = vert && !neg_y && (ay > cfg_i.long_v);
  end

endmodule

// ===== src/tgc_slot_state.sv =====
// tgc_slot_state: per-slot touch points, finger and touch counters, gesture end
// depends on tgc_pkg and tgc_tap_swipe
`timescale 1ns / 1ps

module tgc_slot_state #(
  parameter int unsigned SLOT_COUNT = 16,
  parameter int unsigned COORD_BITS = 12
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        step_i,
  input  logic [tgc_pkg::OpW-1:0]     op_i,
  input  logic [tgc_pkg::SlotW-1:0]   slot_i,
  input  logic [tgc_pkg::PosW-1:0]    pos_x_i,
  input  logic [tgc_pkg::PosW-1:0]    pos_y_i,
  input  tgc_pkg::cfg_t               cfg_i,
  output logic                        emit_o,
  output tgc_pkg::mid_t               mid_o
);

  localparam int unsigned PosW     = tgc_pkg::PosW;
  localparam int unsigned CountW   = tgc_pkg::CountW;
  localparam int unsigned SlotSpan = 1 << tgc_pkg::SlotW;
  localparam int unsigned NSlot    = (SLOT_COUNT < SlotSpan) ? SLOT_COUNT : SlotSpan;
  localparam int unsigned IdxW     = $clog2(NSlot);
  localparam int unsigned StoreW   = (COORD_BITS < PosW) ? COORD_BITS : PosW;
  localparam logic [PosW-1:0] CoordMask = PosW'((1 << StoreW) - 1);

  logic [StoreW-1:0] start_x_q [NSlot];
  logic [StoreW-1:0] start_y_q [NSlot];
  logic [StoreW-1:0] end_x_q [2];
  logic [StoreW-1:0] end_y_q [2];
  logic [CountW-1:0] fingers_q, fingers_d, finger_base;
  logic [CountW-1:0] touches_q, touches_d;

  logic              slot_ok, is_down, is_up;
  logic [IdxW-1:0]   idx;
  logic [PosW-1:0]   x_m, y_m, sx, sy;
  logic [PosW-1:0]   e0x, e0y, e1x, e1y;
  logic [PosW:0]     sep_dx, sep_dy;
  logic [tgc_pkg::MaskW-1:0] single_mask;

  // event decode
  assign slot_ok = (int'(slot_i) < SLOT_COUNT);
  assign is_down = slot_ok && (op_i == tgc_pkg::OP_DOWN);
  assign is_up   = slot_ok && (op_i == tgc_pkg::OP_UP);
  assign idx     = slot_i[IdxW-1:0];
  assign x_m     = pos_x_i & CoordMask;
  assign y_m     = pos_y_i & CoordMask;

  // start point of the lifting slot
  assign sx = PosW'(start_x_q[idx]);
  assign sy = PosW'(start_y_q[idx]);

  // point stores
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NSlot; i++) begin
        start_x_q[i] <= '0;
        start_y_q[i] <= '0;
      end
      for (int i = 0; i < 2; i++) begin
        end_x_q[i] <= '0;
        end_y_q[i] <= '0;
      end
    end else if (step_i) begin
      if (is_down) begin
        start_x_q[idx] <= StoreW'(x_m);
        start_y_q[idx] <= StoreW'(y_m);
      end
      if (is_up && (slot_i < tgc_pkg::SlotW'(2))) begin
        end_x_q[slot_i[0]] <= StoreW'(x_m);
        end_y_q[slot_i[0]] <= StoreW'(y_m);
      end
    end
  end

  // finger count clamps at minus one and restarts from zero on a down
  assign finger_base = fingers_q[CountW-1] ? '0 : fingers_q;

  always_comb begin
    fingers_d = fingers_q;
    touches_d = touches_q;
    if (is_down) begin
      fingers_d = (finger_base != CountW'(tgc_pkg::FingerMax)) ?
                  finger_base + CountW'(1) : finger_base;
      touches_d = (touches_q != CountW'(tgc_pkg::TouchMax)) ?
                  touches_q + CountW'(1) : touches_q;
    end else if (is_up) begin
      fingers_d = (fingers_q != '1) ? fingers_q - CountW'(1) : fingers_q;
      if (emit_o) begin
        touches_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fingers_q <= '0;
      touches_q <= '0;
    end else if (step_i) begin
      fingers_q <= fingers_d;
      touches_q <= touches_d;
    end
  end

  // last finger lifts
  assign emit_o = is_up && (fingers_q == CountW'(1));

  tgc_tap_swipe u_tap_swipe (
    .cfg_i     (cfg_i),
    .pos_x_i   (x_m),
    .pos_y_i   (y_m),
    .start_x_i (sx),
    .start_y_i (sy),
    .mask_o    (single_mask)
  );

  // end points of slots zero and one, with this beat's point forwarded
  assign e0x = (is_up && (slot_i == tgc_pkg::SlotW'(0))) ? x_m : PosW'(end_x_q[0]);
  assign e0y = (is_up && (slot_i == tgc_pkg::SlotW'(0))) ? y_m : PosW'(end_y_q[0]);
  assign e1x = (is_up && (slot_i == tgc_pkg::SlotW'(1))) ? x_m : PosW'(end_x_q[1]);
  assign e1y = (is_up && (slot_i == tgc_pkg::SlotW'(1))) ? y_m : PosW'(end_y_q[1]);
  assign sep_dx = (PosW+1)'(e0x) - (PosW+1)'(e1x);
  assign sep_dy = (PosW+1)'(e0y) - (PosW+1)'(e1y);

  always_comb begin
    mid_o.single_mask = (touches_q == CountW'(1)) ? single_mask : '0;
    mid_o.two_tap     = (touches_q == CountW'(2));
    mid_o.touches     = touches_q;
    mid_o.sep_x       = PosW'(sep_dx[PosW] ? ((PosW+1)'(0) - sep_dx) : sep_dx);
    mid_o.sep_y       = PosW'(sep_dy[PosW] ? ((PosW+1)'(0) - sep_dy) : sep_dy);
  end

endmodule

// ===== src/tgc_wide_check.sv =====
// tgc_wide_check: squared end-point distance of a two-finger gesture against the limit
// depends on tgc_pkg
`timescale 1ns / 1ps

module tgc_wide_check (
  input  tgc_pkg::mid_t  mid_i,
  input  tgc_pkg::cfg_t  cfg_i,
  output logic           wide_o
);

  localparam int unsigned PosW = tgc_pkg::PosW;
  localparam int unsigned SqW  = tgc_pkg::SqW;

  logic [2*PosW-1:0] sq_x, sq_y;
  logic [SqW-1:0]    dist_sq;

  // two squares in parallel, then one add and compare
  assign sq_x    = (2*PosW)'(mid_i.sep_x) * (2*PosW)'(mid_i.sep_x);
  assign sq_y    = (2*PosW)'(mid_i.sep_y) * (2*PosW)'(mid_i.sep_y);
  assign dist_sq = SqW'(sq_x) + SqW'(sq_y);
  assign wide_o  = mid_i.two_tap && (dist_sq >= cfg_i.wide_sq);

endmodule

// ===== src/touch_gesture_classifier_core.sv =====
// touch_gesture_classifier_core: top level of the touch gesture classifier
// depends on tgc_pkg, tgc_if, tgc_cfg_regs, tgc_slot_state, tgc_wide_check
`timescale 1ns / 1ps

// Usage
//   evt_i carries touch events (op, slot, touch_x, touch_y); a beat is taken
//   when valid and ready are both high. Finger down, finger up and other codes
//   are accepted alike; only an up that lifts the last finger makes a result.
//   res_o carries one result beat per finished gesture: tap/swipe mask for a
//   one-touch gesture, two-tap and wide flags for two touches, touch count.
//   The cfg_* port writes a threshold register, with the block idle: the user
//   must keep it idle, as the block itself does not enforce this.
// Timing
//   An event waits in the input register, then updates the slot state, and a
//   result passes the finished gesture register and the distance stage into
//   the result register on res_o. One event per cycle is sustained while res_o
//   is not stalled; the slot state and two 12x12 squares set the per-cycle path.
// Reset and stalls
//   Reset restores the register defaults, clears all stored points and counts.
//   While res_o is stalled the two inner stages keep moving until they hold a
//   beat each; then evt_i ready drops until the result beat is taken.
//   Derived thresholds settle in the cycle after a register write.

module touch_gesture_classifier_core #(
  parameter int unsigned SLOT_COUNT = 16,
  parameter int unsigned COORD_BITS = 12
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  tgc_evt_if.sink                      evt_i,
  tgc_res_if.source                    res_o,
  input  logic                         cfg_we_i,
  input  logic [tgc_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [tgc_pkg::RegW-1:0]     cfg_wdata_i
);

  tgc_pkg::cfg_t cfg;
  tgc_pkg::mid_t mid_d, mid_q;

  logic                        in_vld_q;
  logic [tgc_pkg::OpW-1:0]     in_op_q;
  logic [tgc_pkg::SlotW-1:0]   in_slot_q;
  logic [tgc_pkg::PosW-1:0]    in_x_q, in_y_q;
  logic                        mid_vld_q;
  logic                        out_vld_q;
  logic [tgc_pkg::MaskW-1:0]   out_mask_q;
  logic                        out_two_q, out_wide_q;
  logic [tgc_pkg::CountW-1:0]  out_touch_q;

  logic out_free, mid_free, in_adv, in_free, emit, wide;

  // pipeline flow control
  assign out_free = !out_vld_q || res_o.ready;
  assign mid_free = !mid_vld_q || out_free;
  assign in_adv   = in_vld_q && mid_free;
  assign in_free  = !in_vld_q || mid_free;
  assign evt_i.ready = in_free;

  tgc_cfg_regs u_cfg_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_free) begin
      in_vld_q <= evt_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_free && evt_i.valid) begin
      in_op_q   <= evt_i.op;
      in_slot_q <= evt_i.slot;
      in_x_q    <= evt_i.touch_x;
      in_y_q    <= evt_i.touch_y;
    end
  end

  tgc_slot_state #(
    .SLOT_COUNT (SLOT_COUNT),
    .COORD_BITS (COORD_BITS)
  ) u_slot_state (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (in_adv),
    .op_i    (in_op_q),
    .slot_i  (in_slot_q),
    .pos_x_i (in_x_q),
    .pos_y_i (in_y_q),
    .cfg_i   (cfg),
    .emit_o  (emit),
    .mid_o   (mid_d)
  );

  // finished gesture register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mid_vld_q <= 1'b0;
    end else if (mid_free) begin
      mid_vld_q <= in_adv && emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_adv && emit) begin
      mid_q <= mid_d;
    end
  end

  tgc_wide_check u_wide_check (
    .mid_i  (mid_q),
    .cfg_i  (cfg),
    .wide_o (wide)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_free) begin
      out_vld_q <= mid_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && mid_vld_q) begin
      out_mask_q  <= mid_q.single_mask;
      out_two_q   <= mid_q.two_tap;
      out_wide_q  <= wide;
      out_touch_q <= mid_q.touches;
    end
  end

  assign res_o.valid        = out_vld_q;
  assign res_o.single_mask  = out_mask_q;
  assign res_o.two_tap      = out_two_q;
  assign res_o.two_tap_wide = out_wide_q;
  assign res_o.touches_seen = out_touch_q;

endmodule

// ===== test/touch_gesture_classifier_checker.sv =====
// touch_gesture_classifier_checker: watches the event, result and register ports,
// predicts each finished gesture and compares it; depends on tgc_pkg and tgc_if
`timescale 1ns / 1ps

module touch_gesture_classifier_checker
  import tgc_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  tgc_evt_if                 evt_i,
  tgc_res_if                 res_i,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [RegW-1:0]    cfg_wdata_i,
  output int unsigned        errors_o,
  output int unsigned        pending_o
);

  localparam int unsigned Slots = 16;

  typedef struct packed {
    logic [MaskW-1:0]  single_mask;
    logic              two_tap;
    logic              two_tap_wide;
    logic [CountW-1:0] touches_seen;
  } gesture_t;

  // mirrored block state
  logic [PosW-1:0] start_x [Slots];
  logic [PosW-1:0] start_y [Slots];
  logic [PosW-1:0] end_x [Slots];
  logic [PosW-1:0] end_y [Slots];
  int              fingers_down;
  int unsigned     touch_count;

  // mirrored threshold registers
  logic [RegW-1:0] jitter, long_h, long_v, scr_w, scr_h, wide_dist;

  gesture_t    gesture_q[$];
  int unsigned mismatches;

  // tap and swipe tests on the lifting slot, x and y being the lift position
  function automatic logic [MaskW-1:0] classify_one_touch(input logic [SlotW-1:0] s,
                                                          input int x, input int y);
    int dx, dy, ax, ay, j, lh, lv, w, h, tap_edge, corner;
    bit tap, moved, horiz, vert;
    logic [MaskW-1:0] m;
    dx = int'(end_x[s]) - int'(start_x[s]);
    dy = int'(end_y[s]) - int'(start_y[s]);
    ax = (dx < 0) ? -dx : dx;
    ay = (dy < 0) ? -dy : dy;
    j = int'(jitter);
    lh = int'(long_h);
    lv = int'(long_v);
    w = int'(scr_w);
    h = int'(scr_h);
    tap_edge = int'(TapEdge);
    corner = int'(CornerEdge);
    tap = (ax < j) && (ay < j);
    moved = (ax > j) || (ay > j);
    horiz = moved && (ax > ay);
    vert = moved && (ay > ax);
    // taps by screen region
    m[0] = tap && y > tap_edge && x < w / 3 && (y < h - corner || x > corner);
    m[1] = tap && y > tap_edge && x > (w / 3) * 2;
    m[2] = tap && x > tap_edge && y < h / 3;
    m[3] = tap && x > tap_edge && y > (h / 3) * 2;
    // short swipes
    m[4] = horiz && dx < 0 && dx > -lh;
    m[5] = horiz && dx > 0 && dx < lh;
    m[6] = vert && dy < 0 && dy > -lv;
    m[7] = vert && dy > 0 && dy < lv;
    // long swipes
    m[8] = horiz && dx < 0 && dx < -lh;
    m[9] = horiz && dx > 0 && dx > lh;
    m[10] = vert && dy < 0 && dy < -lv;
    m[11] = vert && dy > 0 && dy > lv;
    return m;
  endfunction

  // squared distance of the end points of slots 0 and 1 against (T+1)^2
  function automatic bit ends_far_apart();
    longint ddx, ddy, t;
    ddx = longint'(end_x[0]) - longint'(end_x[1]);
    ddy = longint'(end_y[0]) - longint'(end_y[1]);
    t = longint'(wide_dist) + 1;
    return (ddx * ddx + ddy * ddy) >= t * t;
  endfunction

  function automatic void apply_touch_event(input logic [OpW-1:0] op,
                                            input logic [SlotW-1:0] s,
                                            input logic [PosW-1:0] x,
                                            input logic [PosW-1:0] y);
    gesture_t done;
    if (op == OP_DOWN) begin
      // a down after a stray up restarts the finger count
      if (fingers_down < 0) fingers_down = 0;
      start_x[s] = x;
      start_y[s] = y;
      if (fingers_down < int'(FingerMax)) fingers_down++;
      if (touch_count < TouchMax) touch_count++;
    end else if (op == OP_UP) begin
      end_x[s] = x;
      end_y[s] = y;
      if (fingers_down > -1) fingers_down--;
      // last finger lifted: the gesture is finished
      if (fingers_down == 0) begin
        done = '0;
        done.touches_seen = CountW'(touch_count);
        if (touch_count == 1) begin
          done.single_mask = classify_one_touch(s, int'(x), int'(y));
        end else if (touch_count == 2) begin
          done.two_tap = 1'b1;
          done.two_tap_wide = ends_far_apart();
        end
        gesture_q.push_back(done);
        touch_count = 0;
      end
    end
  endfunction

  function automatic void compare_field(input string field, input logic [MaskW-1:0] want,
                                        input logic [MaskW-1:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, got %0d", field, want, got);
      mismatches++;
    end
  endfunction

  // result beats are checked before the event of the same edge is predicted
  always @(posedge clk_i) begin
    gesture_t want;
    if (!rst_ni) begin
      for (int i = 0; i < Slots; i++) begin
        start_x[i] = '0;
        start_y[i] = '0;
        end_x[i] = '0;
        end_y[i] = '0;
      end
      fingers_down = 0;
      touch_count = 0;
      jitter = RegW'(JitterRst);
      long_h = RegW'(LongRst);
      long_v = RegW'(LongRst);
      scr_w = RegW'(WidthRst);
      scr_h = RegW'(HeightRst);
      wide_dist = RegW'(WideRst);
      gesture_q.delete();
      mismatches = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_JITTER: jitter = cfg_wdata_i;
          CFG_LONG_H: long_h = cfg_wdata_i;
          CFG_LONG_V: long_v = cfg_wdata_i;
          CFG_WIDTH:  scr_w = cfg_wdata_i;
          CFG_HEIGHT: scr_h = cfg_wdata_i;
          CFG_WIDE:   wide_dist = cfg_wdata_i;
          default: ;
        endcase
      end
      if (res_i.valid && res_i.ready) begin
        if (gesture_q.size() == 0) begin
          $error("result beat with no gesture pending: mask %0d touches %0d",
                 res_i.single_mask, res_i.touches_seen);
          mismatches++;
        end else begin
          want = gesture_q.pop_front();
          compare_field("single_mask", want.single_mask, res_i.single_mask);
          compare_field("two_tap", MaskW'(want.two_tap), MaskW'(res_i.two_tap));
          compare_field("two_tap_wide", MaskW'(want.two_tap_wide), MaskW'(res_i.two_tap_wide));
          compare_field("touches_seen", MaskW'(want.touches_seen), MaskW'(res_i.touches_seen));
        end
      end
      if (evt_i.valid && evt_i.ready) begin
        apply_touch_event(evt_i.op, evt_i.slot, evt_i.touch_x, evt_i.touch_y);
      end
    end
    errors_o <= mismatches;
    pending_o <= gesture_q.size();
  end

endmodule

// ===== test/touch_gesture_classifier_core_test.sv =====
// touch_gesture_classifier_core_test: drives touch events and register writes into
// the classifier under random stalls; depends on tgc_pkg, tgc_if and the checker
`timescale 1ns / 1ps

module touch_gesture_classifier_core_test;
  import tgc_pkg::*;

  localparam logic [OpW-1:0] OpSpare = 2'd3;
  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned DrainCycles = 8;
  localparam int PosMax = 4095;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_we;
  logic [CfgIdxW-1:0] cfg_idx;
  logic [RegW-1:0] cfg_wdata;

  int unsigned errors, pending;
  int unsigned cycles = 0;
  int unsigned send_gap_pct = 15;
  int unsigned recv_stall_pct = 51;
  int unsigned beats_sent = 0;

  // current register values, used to aim coordinates at the thresholds
  int cur_jitter, cur_long_h, cur_long_v, cur_w, cur_h, cur_wide;

  tgc_evt_if evt_ch ();
  tgc_res_if res_ch ();

  touch_gesture_classifier_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .evt_i       (evt_ch),
    .res_o       (res_ch),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  touch_gesture_classifier_checker gesture_check (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .evt_i       (evt_ch),
    .res_i       (res_ch),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .errors_o    (errors),
    .pending_o   (pending)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // run limit
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  // result side back-pressure
  always @(posedge clk_i) begin
    res_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  function automatic int clamp_pos(input int v);
    return (v < 0) ? 0 : ((v > PosMax) ? PosMax : v);
  endfunction

  // coordinate aimed at the region boundaries of a screen span
  function automatic int pick_coord(input int span);
    case ($urandom_range(5))
      0: return int'($urandom_range(PosMax));
      1: return int'($urandom_range(200));
      2: return clamp_pos(span / 3 + int'($urandom_range(4)) - 2);
      3: return clamp_pos((span / 3) * 2 + int'($urandom_range(4)) - 2);
      4: return PosMax - int'($urandom_range(3));
      default: return clamp_pos(span - 150 + int'($urandom_range(4)) - 2);
    endcase
  endfunction

  // signed movement around jitter and swipe length of one axis
  function automatic int pick_offset(input int long_len);
    int mag_v;
    case ($urandom_range(4))
      0: mag_v = int'($urandom_range(cur_jitter));
      1: mag_v = cur_jitter + int'($urandom_range(2)) - 1;
      2: mag_v = long_len + int'($urandom_range(4)) - 2;
      3: mag_v = int'($urandom_range(PosMax));
      default: mag_v = 0;
    endcase
    return $urandom_range(1) ? mag_v : -mag_v;
  endfunction

  // one event beat, with random idle cycles ahead of it
  task automatic send_beat(input logic [OpW-1:0] op, input logic [SlotW-1:0] slot,
                           input int x, input int y);
    while ($urandom_range(99) < send_gap_pct) begin
      evt_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    evt_ch.valid <= 1'b1;
    evt_ch.op <= op;
    evt_ch.slot <= slot;
    evt_ch.touch_x <= PosW'(x);
    evt_ch.touch_y <= PosW'(y);
    @(posedge clk_i);
    while (!evt_ch.ready) @(posedge clk_i);
    if (op == OP_DOWN || op == OP_UP) beats_sent++;
  endtask

  // one finger down and up, sometimes with an ignored beat in between
  task automatic one_touch(input logic [SlotW-1:0] slot, input int sx, input int sy,
                           input int ex, input int ey);
    send_beat(OP_DOWN, slot, sx, sy);
    if ($urandom_range(4) == 0) begin
      send_beat($urandom_range(1) ? OP_OTHER : OpSpare, SlotW'($urandom_range(15)),
                int'($urandom_range(PosMax)), int'($urandom_range(PosMax)));
    end
    send_beat(OP_UP, slot, ex, ey);
  endtask

  // two fingers from random starts to the given end points, lifted in random order
  task automatic two_touch(input logic [SlotW-1:0] s0, input logic [SlotW-1:0] s1,
                           input int x0, input int y0, input int x1, input int y1);
    send_beat(OP_DOWN, s0, pick_coord(cur_w), pick_coord(cur_h));
    send_beat(OP_DOWN, s1, pick_coord(cur_w), pick_coord(cur_h));
    if ($urandom_range(1)) begin
      send_beat(OP_UP, s0, x0, y0);
      send_beat(OP_UP, s1, x1, y1);
    end else begin
      send_beat(OP_UP, s1, x1, y1);
      send_beat(OP_UP, s0, x0, y0);
    end
  endtask

  task automatic random_gesture();
    int kind, sx, sy, x0, y0, x1, y1, n, r;
    logic [SlotW-1:0] s0, s1;
    kind = int'($urandom_range(99));
    if (kind < 45) begin
      // single touch: tap or swipe
      s0 = SlotW'($urandom_range(15));
      sx = pick_coord(cur_w);
      sy = pick_coord(cur_h);
      one_touch(s0, sx, sy, clamp_pos(sx + pick_offset(cur_long_h)),
                clamp_pos(sy + pick_offset(cur_long_v)));
    end else if (kind < 75) begin
      // two touches, mostly on the slots that the distance test looks at
      s0 = '0;
      s1 = 4'd1;
      if ($urandom_range(4) == 0) begin
        s0 = SlotW'($urandom_range(15));
        s1 = SlotW'(int'(s0) + 1 + int'($urandom_range(14)));
      end
      x0 = int'($urandom_range(PosMax));
      y0 = int'($urandom_range(PosMax));
      y1 = y0;
      case ($urandom_range(2))
        0: begin
          x1 = int'($urandom_range(PosMax));
          y1 = int'($urandom_range(PosMax));
        end
        1: begin
          // distance right at the wide threshold
          x1 = x0 + cur_wide + int'($urandom_range(1));
          if (x1 > PosMax) x1 = clamp_pos(x0 - cur_wide - int'($urandom_range(1)));
        end
        default: x1 = clamp_pos(x0 + int'($urandom_range(40)) - 20);
      endcase
      two_touch(s0, s1, x0, y0, x1, y1);
    end else if (kind < 88) begin
      // three or more touches
      n = 3 + int'($urandom_range(3));
      repeat (n) send_beat(OP_DOWN, SlotW'($urandom_range(15)), pick_coord(cur_w),
                           pick_coord(cur_h));
      repeat (n) send_beat(OP_UP, SlotW'($urandom_range(15)), pick_coord(cur_w),
                           pick_coord(cur_h));
    end else begin
      // lone beat of any kind, possibly unbalancing the finger count
      r = int'($urandom_range(9));
      send_beat((r < 5) ? OP_UP : ((r < 8) ? OP_DOWN : ((r < 9) ? OP_OTHER : OpSpare)),
                SlotW'($urandom_range(15)), int'($urandom_range(PosMax)),
                int'($urandom_range(PosMax)));
    end
  endtask

  task automatic random_run(input int unsigned target);
    int unsigned first;
    first = beats_sent;
    while (beats_sent - first < target) random_gesture();
  endtask

  // wait for every pending gesture plus the pipeline depth
  task automatic settle();
    evt_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic program_regs(input int j, input int lh, input int lv, input int w,
                              input int h, input int wd);
    cur_jitter = j;
    cur_long_h = lh;
    cur_long_v = lv;
    cur_w = w;
    cur_h = h;
    cur_wide = wd;
    cfg_we <= 1'b1;
    cfg_idx <= CFG_JITTER;
    cfg_wdata <= RegW'(j);
    @(posedge clk_i);
    cfg_idx <= CFG_LONG_H;
    cfg_wdata <= RegW'(lh);
    @(posedge clk_i);
    cfg_idx <= CFG_LONG_V;
    cfg_wdata <= RegW'(lv);
    @(posedge clk_i);
    cfg_idx <= CFG_WIDTH;
    cfg_wdata <= RegW'(w);
    @(posedge clk_i);
    cfg_idx <= CFG_HEIGHT;
    cfg_wdata <= RegW'(h);
    @(posedge clk_i);
    cfg_idx <= CFG_WIDE;
    cfg_wdata <= RegW'(wd);
    @(posedge clk_i);
    cfg_we <= 1'b0;
    @(posedge clk_i);
  endtask

  initial begin
    rst_ni <= 1'b0;
    evt_ch.valid <= 1'b0;
    evt_ch.op <= OP_DOWN;
    evt_ch.slot <= '0;
    evt_ch.touch_x <= '0;
    evt_ch.touch_y <= '0;
    cfg_we <= 1'b0;
    cfg_idx <= CFG_JITTER;
    cfg_wdata <= '0;
    cur_jitter = JitterRst;
    cur_long_h = LongRst;
    cur_long_v = LongRst;
    cur_w = WidthRst;
    cur_h = HeightRst;
    cur_wide = WideRst;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: stray ups, ignored codes, taps, swipes, two-finger taps
    send_beat(OP_UP, 4'd5, 10, 10);
    send_beat(OP_UP, 4'd5, PosMax, 0);
    send_beat(OP_OTHER, 4'd15, PosMax, PosMax);
    send_beat(OpSpare, 4'd0, 0, 0);
    one_touch(4'd0, 200, 900, 205, 903);
    one_touch(4'd15, PosMax, PosMax, PosMax, PosMax);
    one_touch(4'd2, 700, 300, 702, 301);
    one_touch(4'd3, 0, 2000, PosMax, 2000);
    one_touch(4'd6, 500, 1000, 500, 700);
    one_touch(4'd7, 500, 0, 500, PosMax);
    one_touch(4'd8, 500, 500, 1100, 500);
    two_touch(4'd0, 4'd1, 0, 0, PosMax, PosMax);
    two_touch(4'd0, 4'd1, 100, 100, 501, 100);

    // finger and touch counters driven into saturation
    repeat (70) send_beat(OP_DOWN, SlotW'($urandom_range(15)), int'($urandom_range(PosMax)),
                          int'($urandom_range(PosMax)));
    repeat (33) send_beat(OP_UP, SlotW'($urandom_range(15)), int'($urandom_range(PosMax)),
                          int'($urandom_range(PosMax)));
    random_run(120);

    // low extreme of every register
    settle();
    program_regs(0, 0, 0, 1, 1, 0);
    random_run(80);

    // senders stall more than receivers from here, high extremes
    settle();
    send_gap_pct = 51;
    recv_stall_pct = 15;
    program_regs(PosMax, PosMax, PosMax, PosMax, PosMax, PosMax);
    random_run(120);

    settle();
    program_regs(1 + int'($urandom_range(200)), 50 + int'($urandom_range(1500)),
                 50 + int'($urandom_range(1500)), 1 + int'($urandom_range(4094)),
                 1 + int'($urandom_range(4094)), int'($urandom_range(PosMax)));
    random_run(160);

    // no idling on either side
    settle();
    send_gap_pct = 0;
    recv_stall_pct = 0;
    program_regs(int'($urandom_range(PosMax)), int'($urandom_range(PosMax)),
                 int'($urandom_range(PosMax)), 1 + int'($urandom_range(4094)),
                 1 + int'($urandom_range(4094)), int'($urandom_range(PosMax)));
    random_run(80);
    settle();
    program_regs(JitterRst, LongRst, LongRst, WidthRst, HeightRst, WideRst);
    random_run(120);

    settle();
    if (errors == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/tgc_pkg.sv
src/tgc_if.sv
src/tgc_cfg_regs.sv
src/tgc_tap_swipe.sv
src/tgc_slot_state.sv
src/tgc_wide_check.sv
src/touch_gesture_classifier_core.sv
test/touch_gesture_classifier_checker.sv
test/touch_gesture_classifier_core_test.sv
